[rtl/core/bsl_pkg.sv]
// Shared types and constants of the bounded sorted list block.
// Used by the channel interfaces, the cell, the top level and the checker.
package bsl_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 2;
  localparam int POS_W     = 5;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 5;
  localparam int CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND  = 2'd0,
    ACT_AT_POS  = 2'd1,
    ACT_ORDERED = 2'd2,
    ACT_DUMP    = 2'd3
  } bsl_action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_RSVD   = 2'd3
  } bsl_status_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              we;
    logic              ordered;
    logic [DATA_W-1:0] value;
  } bsl_bcast_t;

  // Per-cell select bits.
  typedef struct packed {
    logic valid;  // cell holds a stored entry
    logic tgt;    // cell sits at the explicit target index
  } bsl_sel_t;

endpackage

[rtl/core/bsl_in_if.sv]
// Input channel of the bounded sorted list block: valid/ready plus one item.
// Depends on bsl_pkg for field widths.
interface bsl_in_if
  import bsl_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

[rtl/core/bsl_out_if.sv]
// Result channel of the bounded sorted list block: valid/ready plus one result.
// Depends on bsl_pkg for field widths.
interface bsl_out_if
  import bsl_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     is_element;
  logic signed [DATA_W-1:0] element;
  logic [CNT_W-1:0]         count;
  logic                     last;

  modport source (output valid, status, is_element, element, count, last, input ready);
  modport sink   (input valid, status, is_element, element, count, last, output ready);
endinterface

[rtl/core/bsl_cell.sv]
// One storage cell of the list chain: holds an entry, compares it against the
// broadcast value and shifts in its lower neighbor's entry. Depends on bsl_pkg.
module bsl_cell
  import bsl_pkg::*;
(
  input  logic              clk,
  input  bsl_bcast_t        bc,
  input  bsl_sel_t          sel,
  input  logic [DATA_W-1:0] prev_entry,
  input  logic              found_in,
  output logic [DATA_W-1:0] entry,
  output logic              found_out
);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic              not_less;
  logic              here;

  // Ordered insert lands before the first stored entry not smaller than value.
  assign not_less  = !($signed(bc.value) > $signed(entry_r));
  assign here      = bc.ordered ? ((sel.valid && not_less) || sel.tgt) : sel.tgt;
  assign found_out = found_in || here;

  always_comb begin
    entry_nxt = entry_r;
    if (bc.we) begin
      if (found_in) begin
        entry_nxt = prev_entry;     // shift up one place
      end else if (here) begin
        entry_nxt = bc.value;       // drop the new value in
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[rtl/core/bounded_sorted_list_insert.sv]
// Bounded sorted list: top level. Instantiates the bsl_cell chain and holds
// the controller, count, capacity register and the result register.
//
// A list of up to DEPTH signed 32-bit entries kept in a chain of cells, one
// entry per cell. Every insert (append, insert at position, ordered insert)
// is decided combinationally: all cells compare against the new value at
// once, the first matching cell takes the value and every cell above it takes
// its lower neighbor's entry. A new item is taken every cycle as long as no
// dump runs and the result side keeps up; its single result beat sits in an
// output register, and while that beat waits the input is held off, so the
// next item is accepted at the edge where the waiting beat is taken. A dump
// reads one cell per cycle through the output register while the result side
// keeps up, and no new item is taken while it runs.
// The capacity register (cfg_we/cfg_data) is clamped to DEPTH when read; inserts
// while the count is at or above it report full. Reset sets only the control
// registers, not the entries; cells at or above the count are never read.
module bounded_sorted_list_insert
  import bsl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bsl_in_if.sink           in_ch,
  bsl_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int CW   = $clog2(DEPTH + 1);          // count width
  localparam int IW   = $clog2(DEPTH);              // cell index width
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;  // common compare width

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic              out_iselem_r, out_iselem_nxt;
  logic [DATA_W-1:0] out_elem_r, out_elem_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic              in_fire;
  logic              is_dump;
  logic [CMPW-1:0]   count_x, pos_x, cap_x, eff_cap, tgt_x;
  logic [STAT_W-1:0] ins_status;
  logic [CW-1:0]     next_idx_cnt;

  bsl_bcast_t        bc;
  bsl_sel_t          sel   [DEPTH];
  logic [DATA_W-1:0] ent   [DEPTH];
  logic [DEPTH:0]    found;

  // Handshake: a free result slot and an idle controller take the next beat.
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_dump     = (in_ch.action == ACT_DUMP);

  // Full check first, then position check.
  assign count_x = CMPW'(count_r);
  assign pos_x   = CMPW'(in_ch.position);
  assign cap_x   = CMPW'(cap_r);
  assign eff_cap = (cap_x > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_x;

  always_comb begin
    if (count_x >= eff_cap) begin
      ins_status = ST_FULL;
    end else if ((in_ch.action == ACT_AT_POS) && (pos_x > count_x)) begin
      ins_status = ST_BADPOS;
    end else begin
      ins_status = ST_OK;
    end
  end

  // Explicit target: the position for insert-at-position, else the tail.
  assign tgt_x = (in_ch.action == ACT_AT_POS) ? pos_x : count_x;

  assign bc.we      = in_fire && !is_dump && (ins_status == ST_OK);
  assign bc.ordered = (in_ch.action == ACT_ORDERED);
  assign bc.value   = in_ch.value;

  // Cell chain: the found flag and the entries ripple up the row.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign sel[i].valid = (CW'(i) < count_r);
    assign sel[i].tgt   = (tgt_x == CMPW'(i));

    bsl_cell u_cell (
      .clk        (clk),
      .bc         (bc),
      .sel        (sel[i]),
      .prev_entry ((i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1]),
      .found_in   (found[i]),
      .entry      (ent[i]),
      .found_out  (found[i+1])
    );
  end

  assign next_idx_cnt = CW'(idx_r) + CW'(1);

  // Controller and result register.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cap_nxt        = cap_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_iselem_nxt = out_iselem_r;
    out_elem_nxt   = out_elem_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    if (cfg_we) begin
      cap_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          if (is_dump) begin
            out_status_nxt = ST_OK;
            out_count_nxt  = CNT_W'(count_r);
            if (count_r == '0) begin
              // Empty list: one marker beat.
              out_iselem_nxt = 1'b0;
              out_elem_nxt   = '0;
              out_last_nxt   = 1'b1;
            end else begin
              out_iselem_nxt = 1'b1;
              out_elem_nxt   = ent[0];
              out_last_nxt   = (count_r == CW'(1));
              if (count_r != CW'(1)) begin
                idx_nxt   = IW'(1);
                state_nxt = S_DUMP;
              end
            end
          end else begin
            if (ins_status == ST_OK) begin
              count_nxt = count_r + CW'(1);
            end
            out_status_nxt = ins_status;
            out_iselem_nxt = 1'b0;
            out_elem_nxt   = '0;
            out_count_nxt  = (ins_status == ST_OK) ? CNT_W'(count_r + CW'(1))
                                                   : CNT_W'(count_r);
            out_last_nxt   = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          // Emit the next stored entry; advance until the tail.
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_iselem_nxt = 1'b1;
          out_elem_nxt   = ent[idx_r];
          out_count_nxt  = CNT_W'(count_r);
          out_last_nxt   = (next_idx_cnt == count_r);
          idx_nxt        = IW'(next_idx_cnt);
          if (next_idx_cnt == count_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      cap_r       <= CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_iselem_r <= out_iselem_nxt;
    out_elem_r   <= out_elem_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.is_element = out_iselem_r;
  assign out_ch.element    = out_elem_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.last       = out_last_r;

endmodule

[rtl/core/bsl_checker.sv]
// Port-level checker for bounded_sorted_list_insert, attached by bind.
// Depends on bsl_pkg for widths and status codes.
module bsl_checker
  import bsl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic              out_is_element,
  input logic [DATA_W-1:0] out_element,
  input logic [CNT_W-1:0]  out_count,
  input logic              out_last
);

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_status, out_is_element, out_element, out_count, out_last}))
    else $error("result beat changed while stalled");

  // Refused inserts carry no element and close their item.
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_is_element && out_last)
    else $error("error result with element or without last");

  // A beat without an element is a single-beat result with a zero element.
  a_no_elem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_element |-> (out_element == '0) && out_last)
    else $error("non-element beat with nonzero element or without last");

  // No new item is taken while a dump still has entries to send.
  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_element && !out_last |-> !(in_valid && in_ready))
    else $error("item accepted in the middle of a dump");

endmodule

bind bounded_sorted_list_insert bsl_checker u_bsl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_is_element (out_ch.is_element),
  .out_element    (out_ch.element),
  .out_count      (out_ch.count),
  .out_last       (out_ch.last)
);

[tb/sv/bounded_sorted_list_insert_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bounded_sorted_list_insert: a driver and a monitor on the
// valid/ready channels plus a built-in list predictor. Depends on bsl_pkg, bsl_in_if,
// bsl_out_if and the block itself.
module bounded_sorted_list_insert_tb;
  import bsl_pkg::*;

  localparam int unsigned HOLD_LEN       = 200;   // long receiver hold-off, in cycles
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int unsigned SETTLE_CYCLES  = 20;    // extra cycles after the last result

  // One item as the generator queues it, and one result beat as predicted.
  typedef struct {
    bsl_action_t              action;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } list_op_t;

  typedef struct {
    bsl_status_t              status;
    logic                     is_element;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } list_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  bsl_in_if  in_ch ();
  bsl_out_if out_ch ();

  bounded_sorted_list_insert i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Items waiting to be offered, and result beats waiting to arrive.
  list_op_t   list_ops[$];
  list_beat_t predicted_beats[$];

  // Predictor state: the list contents, the entry count and the capacity register.
  logic signed [DATA_W-1:0] list_vals [DEPTH_DEF];
  int unsigned              list_count = 0;
  logic [CAP_W-1:0]         cap_shadow;

  // Traffic shaping: rates and hold requests set by the stimulus process at falling edges.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;

  // Generator-side estimate of the count, used only to aim positions.
  int unsigned est_count = 0;
  int unsigned gen_room  = DEPTH_DEF;

  int unsigned mismatches = 0;
  int unsigned quiet      = 0;
  list_op_t    offered_op;
  list_beat_t  want_beat;

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function automatic void post_beat(bsl_status_t st, logic is_el,
                                    logic signed [DATA_W-1:0] el, int unsigned cnt,
                                    logic fin);
    list_beat_t b;
    b.status     = st;
    b.is_element = is_el;
    b.element    = el;
    b.count      = cnt[CNT_W-1:0];
    b.last       = fin;
    predicted_beats.push_back(b);
  endfunction

  // Apply one accepted item to the shadow list and queue the beats it must produce.
  function automatic void list_apply(list_op_t op);
    int unsigned room;
    int unsigned slot;
    room = (cap_shadow > DEPTH_DEF) ? DEPTH_DEF : cap_shadow;
    // Dump: one beat per entry, or a single empty marker; the list is untouched.
    if (op.action == ACT_DUMP) begin
      if (list_count == 0) begin
        post_beat(ST_OK, 1'b0, '0, 0, 1'b1);
      end else begin
        for (int unsigned i = 0; i < list_count; i++)
          post_beat(ST_OK, 1'b1, list_vals[i], list_count, i == list_count - 1);
      end
      return;
    end
    // Full is checked ahead of the position; a capacity below the count is full too.
    if (list_count >= room) begin
      post_beat(ST_FULL, 1'b0, '0, list_count, 1'b1);
      return;
    end
    case (op.action)
      ACT_APPEND: slot = list_count;
      ACT_AT_POS: begin
        if (op.position > list_count) begin
          post_beat(ST_BADPOS, 1'b0, '0, list_count, 1'b1);
          return;
        end
        slot = op.position;
      end
      default: begin
        // Ordered: stop at the first stored entry that is not smaller.
        slot = 0;
        while (slot < list_count && op.value > list_vals[slot]) slot++;
      end
    endcase
    for (int unsigned k = list_count; k > slot; k--) list_vals[k] = list_vals[k - 1];
    list_vals[slot] = op.value;
    list_count++;
    post_beat(ST_OK, 1'b0, '0, list_count, 1'b1);
  endfunction

  // Track the capacity register exactly at the edge the block takes the write.
  always @(posedge clk) begin
    if (!rst_n) cap_shadow <= CAP_RST;
    else if (cfg_we) cap_shadow <= cfg_data;
  end

  // Driver: predict on every accepted beat, then offer the next item or idle.
  // Valid stays up until the beat is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) list_apply(offered_op);
      if (!in_ch.valid || in_ch.ready) begin
        if (list_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_op = list_ops.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.action   <= offered_op.action;
          in_ch.value    <= offered_op.value;
          in_ch.position <= offered_op.position;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off: count the stretch here, apart from the per-cycle stall draw.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      hold_left   <= HOLD_LEN;
      hold_served <= hold_served + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_beats.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing pending: status %0d is_element %0b element %0d count %0d last %0b",
                                out_ch.status, out_ch.is_element, out_ch.element,
                                out_ch.count, out_ch.last));
      end else begin
        want_beat = predicted_beats.pop_front();
        if (out_ch.status !== want_beat.status || out_ch.is_element !== want_beat.is_element
            || out_ch.element !== want_beat.element || out_ch.count !== want_beat.count
            || out_ch.last !== want_beat.last)
          flag_mismatch($sformatf({"expected status %0d is_element %0b element %0d count %0d ",
                                   "last %0b, got status %0d is_element %0b element %0d ",
                                   "count %0d last %0b"},
                                  want_beat.status, want_beat.is_element, want_beat.element,
                                  want_beat.count, want_beat.last, out_ch.status,
                                  out_ch.is_element, out_ch.element, out_ch.count,
                                  out_ch.last));
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("bounded_sorted_list_insert regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Wait until every item has been taken and every predicted beat has arrived.
  task automatic drain();
    do @(negedge clk);
    while (list_ops.size() != 0 || in_ch.valid || predicted_beats.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    gen_room = (cap > DEPTH_DEF) ? DEPTH_DEF : cap;
  endtask

  task automatic push_op(bsl_action_t action, logic signed [DATA_W-1:0] value,
                         logic [POS_W-1:0] position);
    list_op_t op;
    op.action   = action;
    op.value    = value;
    op.position = position;
    list_ops.push_back(op);
    if (action != ACT_DUMP && est_count < gen_room
        && !(action == ACT_AT_POS && position > est_count))
      est_count++;
  endtask

  // Mix extremes, copies of stored entries (to hit equal keys), small and wide values.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return {1'b1, {(DATA_W-1){1'b0}}};
        1:       return {1'b0, {(DATA_W-1){1'b1}}};
        2:       return '1;
        default: return '0;
      endcase
    end
    if (r < 35 && list_count != 0) return list_vals[$urandom_range(0, list_count - 1)];
    if (r < 50) return $signed(DATA_W'($urandom_range(0, 64))) - 32;
    return $urandom();
  endfunction

  // Mostly legal positions up to the expected count; sometimes anything the field holds.
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, est_count));
    return POS_W'($urandom_range(0, 31));
  endfunction

  // One round: inserts of all kinds and dumps with random content, closed by a dump.
  task automatic run_round(int unsigned n);
    int unsigned r;
    est_count = list_count;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (k == n - 1 || r >= 80) push_op(ACT_DUMP, $urandom(), POS_W'($urandom()));
      else if (r < 20) push_op(ACT_APPEND, pick_value(), POS_W'($urandom()));
      else if (r < 45) push_op(ACT_AT_POS, pick_value(), pick_position());
      else push_op(ACT_ORDERED, pick_value(), POS_W'($urandom()));
    end
  endtask

  initial begin
    logic [CAP_W-1:0] next_cap;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_APPEND;
    in_ch.value    = '0;
    in_ch.position = '0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = CAP_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: dump of the empty list at the reset capacity.
    push_op(ACT_DUMP, '0, '0);

    // Capacity zero refuses every insert kind.
    write_capacity('0);
    push_op(ACT_APPEND, 32'sd5, '0);
    push_op(ACT_AT_POS, 32'sd6, '0);
    push_op(ACT_ORDERED, 32'sd7, '0);
    push_op(ACT_DUMP, '0, '0);

    // Capacity one: positions past the count, then one entry, then full.
    write_capacity(5'd1);
    push_op(ACT_AT_POS, 32'sd9, 5'd1);
    push_op(ACT_AT_POS, 32'hFFFF_FFFF, 5'd31);
    push_op(ACT_AT_POS, 32'sh7FFF_FFFF, 5'd0);
    push_op(ACT_APPEND, 32'sd1, '0);
    push_op(ACT_DUMP, '0, '0);

    // Capacity above the depth clamps: extremes, equal keys, position equal to count.
    write_capacity(5'd31);
    push_op(ACT_APPEND, 32'h8000_0000, '0);
    push_op(ACT_ORDERED, 32'sd0, '0);
    push_op(ACT_ORDERED, 32'sh7FFF_FFFF, '0);
    push_op(ACT_ORDERED, 32'hFFFF_FFFF, '0);
    push_op(ACT_AT_POS, 32'h5555_5555, 5'd5);
    push_op(ACT_AT_POS, 32'hAAAA_AAAA, 5'd0);
    push_op(ACT_ORDERED, 32'h8000_0000, '0);
    push_op(ACT_ORDERED, 32'sd123, '0);
    push_op(ACT_DUMP, '0, '0);

    // Capacity lowered below the count: append and insert-at-position both report full.
    write_capacity(5'd3);
    push_op(ACT_APPEND, 32'sd11, '0);
    push_op(ACT_AT_POS, 32'sd12, 5'd0);

    // Random rounds over four traffic phases; the capacity creeps up so that
    // inserts keep landing until the list finally fills.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int r = 0; r < 4; r++) begin
        if ($urandom_range(0, 99) < 15) next_cap = CAP_W'($urandom_range(0, 31));
        else if (list_count + 3 >= 31) next_cap = 5'd31;
        else next_cap = CAP_W'(list_count + $urandom_range(1, 3));
        if (ph == 3 && r == 3) next_cap = 5'd16;
        write_capacity(next_cap);
        // Hold results back while items keep coming, so the block backs up.
        if (ph == 0 && r == 1) begin
          hold_reqs++;
          run_round(16);
        end else begin
          run_round($urandom_range(8, 14));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_beats.size() != 0)
      flag_mismatch($sformatf("%0d predicted beats never arrived", predicted_beats.size()));
    if (mismatches == 0) begin
      $display("bounded_sorted_list_insert regression: pass");
    end else begin
      $display("bounded_sorted_list_insert regression: fail");
    end
    $finish;
  end

endmodule

[bounded_sorted_list_insert.f]
rtl/core/bsl_pkg.sv
rtl/core/bsl_in_if.sv
rtl/core/bsl_out_if.sv
rtl/core/bsl_cell.sv
rtl/core/bounded_sorted_list_insert.sv
rtl/core/bsl_checker.sv
tb/sv/bounded_sorted_list_insert_tb.sv
